// ----- rtl/mm_pkg.sv -----
`timescale 1ns / 1ps

package mm_pkg;

  localparam int IDX_W       = 3;
  localparam int CFG_W       = 4;
  localparam int PROD_W      = 36;
  localparam int OP_W        = 2;
  localparam int DEF_MAX_DIM = 8;
  localparam int DEF_ELEM_W  = 16;

  localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
  localparam logic [OP_W-1:0] OP_MUL    = 2'd2;

  localparam logic [1:0] REG_A_ROWS    = 2'd0;
  localparam logic [1:0] REG_INNER_DIM = 2'd1;
  localparam logic [1:0] REG_B_COLS    = 2'd2;

  // Control that travels along the cell row with each A element.
  typedef struct packed {
    logic             valid;
    logic             first;
    logic [IDX_W-1:0] k;
  } feed_ctl_t;

  // Write of one B element into the cell that owns its column.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } b_wr_t;

endpackage

// ----- rtl/mm_cell.sv -----
`timescale 1ns / 1ps

module mm_cell #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16,
  parameter int COL        = 0
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  mm_pkg::feed_ctl_t                    ctl_i,
  input  logic signed [ELEM_WIDTH-1:0]         a_i,
  input  mm_pkg::b_wr_t                        b_wr_i,
  input  logic signed [ELEM_WIDTH-1:0]         b_data_i,
  output mm_pkg::feed_ctl_t                    ctl_o,
  output logic signed [ELEM_WIDTH-1:0]         a_o,
  output logic signed [mm_pkg::PROD_W-1:0]     acc_o
);
  import mm_pkg::*;

  localparam int IW = $clog2(MAX_DIM);

  // This cell keeps column COL of B.
  logic signed [ELEM_WIDTH-1:0]   b_col_r [MAX_DIM];
  logic signed [ELEM_WIDTH-1:0]   b_sel;
  logic signed [2*ELEM_WIDTH-1:0] prod;
  logic signed [PROD_W-1:0]       prod_ext;
  feed_ctl_t                      ctl_r;
  logic signed [ELEM_WIDTH-1:0]   a_r;
  logic signed [PROD_W-1:0]       acc_r;

  assign b_sel    = b_col_r[ctl_i.k[IW-1:0]];
  assign prod     = a_i * b_sel;
  assign prod_ext = PROD_W'(prod);

  always_ff @(posedge clk) begin
    if (b_wr_i.en && (b_wr_i.col == IDX_W'(COL))) begin
      b_col_r[b_wr_i.row[IW-1:0]] <= b_data_i;
    end
    if (ctl_i.valid) begin
      acc_r <= ctl_i.first ? prod_ext : acc_r + prod_ext;
    end
    a_r <= a_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  assign ctl_o = ctl_r;
  assign a_o   = a_r;
  assign acc_o = acc_r;

endmodule

// ----- rtl/mm_cell_row.sv -----
`timescale 1ns / 1ps

module mm_cell_row #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  mm_pkg::feed_ctl_t                ctl_i,
  input  logic signed [ELEM_WIDTH-1:0]     a_i,
  input  mm_pkg::b_wr_t                    b_wr_i,
  input  logic signed [ELEM_WIDTH-1:0]     b_data_i,
  output logic signed [mm_pkg::PROD_W-1:0] acc_o [MAX_DIM]
);
  import mm_pkg::*;

  feed_ctl_t                    ctl_w [MAX_DIM+1];
  logic signed [ELEM_WIDTH-1:0] a_w   [MAX_DIM+1];

  assign ctl_w[0] = ctl_i;
  assign a_w[0]   = a_i;

  // Each A element walks one cell per cycle; cell j adds into its column sum.
  for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
    mm_cell #(
      .MAX_DIM   (MAX_DIM),
      .ELEM_WIDTH(ELEM_WIDTH),
      .COL       (j)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl_i   (ctl_w[j]),
      .a_i     (a_w[j]),
      .b_wr_i  (b_wr_i),
      .b_data_i(b_data_i),
      .ctl_o   (ctl_w[j+1]),
      .a_o     (a_w[j+1]),
      .acc_o   (acc_o[j])
    );
  end

endmodule

// ----- rtl/matrix_multiply.sv -----
// Loads may follow back to back.
// A multiply works per product row: the A row streams through the cell row, drains
// MAX_DIM cells, then cols results unload.
// No item is accepted while a multiply runs; one result register decouples the output.
// Synchronous active-low reset clears control and sets all dimensions to 1.
// The A and B stores are not cleared and hold unknown data until written.
`timescale 1ns / 1ps

module matrix_multiply #(
  parameter int MAX_DIM    = mm_pkg::DEF_MAX_DIM,
  parameter int ELEM_WIDTH = mm_pkg::DEF_ELEM_W
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [mm_pkg::OP_W-1:0]          in_operation,
  input  logic [mm_pkg::IDX_W-1:0]         in_row_index,
  input  logic [mm_pkg::IDX_W-1:0]         in_col_index,
  input  logic signed [15:0]               in_element_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mm_pkg::IDX_W-1:0]         out_row,
  output logic [mm_pkg::IDX_W-1:0]         out_col,
  output logic signed [mm_pkg::PROD_W-1:0] out_product_value,
  output logic                             out_last_result,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [3:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import mm_pkg::*;

  localparam int IW    = $clog2(MAX_DIM);
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_FEED, S_DRAIN, S_EMIT} state_t;

  state_t                   state_r;
  logic [CFG_W-1:0]         a_rows_r, inner_dim_r, b_cols_r;
  logic [IW-1:0]            r_r, k_r, c_r, cnt_r;
  feed_ctl_t                feed_r;
  logic signed [ELEM_WIDTH-1:0] a_mem [DEPTH];
  logic signed [ELEM_WIDTH-1:0] a_q_r;
  logic                     out_valid_r, out_last_r;
  logic [IDX_W-1:0]         out_row_r, out_col_r;
  logic signed [PROD_W-1:0] out_prod_r;

  logic [CFG_W-1:0]         rows_c, inner_c, cols_c;
  logic [IW-1:0]            rows_m1, inner_m1, cols_m1;
  logic                     in_xfer, idx_ok, cfg_wr, emit_go, emit_last;
  logic [AW-1:0]            ld_addr, rd_addr;
  logic signed [ELEM_WIDTH-1:0] elem;
  b_wr_t                    b_wr;
  logic signed [PROD_W-1:0] acc [MAX_DIM];

  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] d);
    if (d == '0) begin
      return CFG_W'(1);
    end else if (d > CFG_W'(MAX_DIM)) begin
      return CFG_W'(MAX_DIM);
    end
    return d;
  endfunction

  assign rows_c   = clamp_dim(a_rows_r);
  assign inner_c  = clamp_dim(inner_dim_r);
  assign cols_c   = clamp_dim(b_cols_r);
  assign rows_m1  = IW'(rows_c - CFG_W'(1));
  assign inner_m1 = IW'(inner_c - CFG_W'(1));
  assign cols_m1  = IW'(cols_c - CFG_W'(1));

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign idx_ok   = ({1'b0, in_row_index} < (IDX_W+1)'(MAX_DIM)) &&
                    ({1'b0, in_col_index} < (IDX_W+1)'(MAX_DIM));
  assign elem     = ELEM_WIDTH'(in_element_value);
  assign ld_addr  = AW'(in_row_index[IW-1:0] * MAX_DIM + in_col_index[IW-1:0]);
  assign rd_addr  = AW'(r_r * MAX_DIM + k_r);

  assign b_wr.en  = in_xfer && idx_ok && (in_operation == OP_LOAD_B);
  assign b_wr.row = in_row_index;
  assign b_wr.col = in_col_index;

  assign emit_go   = (state_r == S_EMIT) && (!out_valid_r || out_ready);
  assign emit_last = (r_r == rows_m1) && (c_r == cols_m1);

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[3:2])
      REG_A_ROWS:    prdata = 32'(a_rows_r);
      REG_INNER_DIM: prdata = 32'(inner_dim_r);
      REG_B_COLS:    prdata = 32'(b_cols_r);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_rows_r    <= CFG_W'(1);
      inner_dim_r <= CFG_W'(1);
      b_cols_r    <= CFG_W'(1);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_A_ROWS:    a_rows_r    <= pwdata[CFG_W-1:0];
        REG_INNER_DIM: inner_dim_r <= pwdata[CFG_W-1:0];
        REG_B_COLS:    b_cols_r    <= pwdata[CFG_W-1:0];
        default:       ;
      endcase
    end
  end

  // A store, registered read.
  always_ff @(posedge clk) begin
    if (in_xfer && idx_ok && (in_operation == OP_LOAD_A)) begin
      a_mem[ld_addr] <= elem;
    end
    a_q_r <= a_mem[rd_addr];
  end

  // Sequencer: per product row, feed the A row, let the cell row drain, unload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      r_r         <= '0;
      k_r         <= '0;
      c_r         <= '0;
      cnt_r       <= '0;
      feed_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      feed_r.valid <= (state_r == S_FEED);
      feed_r.first <= (k_r == '0);
      feed_r.k     <= IDX_W'(k_r);
      out_valid_r  <= emit_go || (out_valid_r && !out_ready);
      case (state_r)
        S_IDLE: begin
          if (in_xfer && (in_operation == OP_MUL)) begin
            r_r     <= '0;
            k_r     <= '0;
            state_r <= S_FEED;
          end
        end
        S_FEED: begin
          if (k_r == inner_m1) begin
            cnt_r   <= '0;
            state_r <= S_DRAIN;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_DRAIN: begin
          // Wait here until the last element has passed the read register and every cell of the row.
          if (cnt_r == IW'(MAX_DIM - 1)) begin
            c_r     <= '0;
            state_r <= S_EMIT;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            out_row_r   <= IDX_W'(r_r);
            out_col_r   <= IDX_W'(c_r);
            out_prod_r  <= acc[c_r];
            out_last_r  <= emit_last;
            if (c_r == cols_m1) begin
              if (r_r == rows_m1) begin
                state_r <= S_IDLE;
              end else begin
                r_r     <= r_r + 1'b1;
                k_r     <= '0;
                state_r <= S_FEED;
              end
            end else begin
              c_r <= c_r + 1'b1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  mm_cell_row #(
    .MAX_DIM   (MAX_DIM),
    .ELEM_WIDTH(ELEM_WIDTH)
  ) u_row (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (feed_r),
    .a_i     (a_q_r),
    .b_wr_i  (b_wr),
    .b_data_i(elem),
    .acc_o   (acc)
  );

  assign out_valid         = out_valid_r;
  assign out_row           = out_row_r;
  assign out_col           = out_col_r;
  assign out_product_value = out_prod_r;
  assign out_last_result   = out_last_r;

`ifndef SYNTH
  a_feed_origin: assert property (@(posedge clk) disable iff (!rst_n)
    feed_r.valid |-> $past(state_r) == S_FEED)
    else $error("cell row fed outside the feed phase");

  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FEED) |-> (k_r <= inner_m1))
    else $error("inner index ran past the inner size");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_go && emit_last) |=> (state_r == S_IDLE) && out_valid_r && out_last_r)
    else $error("final result did not end the run");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> !(state_r == S_EMIT && emit_go && !out_ready))
    else $error("result register overwritten while stalled");
`endif

endmodule
